### design/pf2b_pkg.sv
// pf2b_pkg: shared constants, codes and types of the pixel format to bgr24 converter
// no dependencies; imported by every module of the block

package pf2b_pkg;

    localparam int MAX_WIDTH       = 4096;
    localparam int MAX_HEIGHT      = 4096;
    localparam int PALETTE_ENTRIES = 256;

    // register and field widths
    localparam int DIM_W    = 13;
    localparam int MODE_W   = 3;
    localparam int IDX_W    = 2;
    localparam int OFFSET_W = 26;
    localparam int PIX_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int DATA_W   = 3 * BYTE_W;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int ROWB_W  = $clog2(MAX_WIDTH * 3 + 4);
    localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

    // depth modes
    localparam logic [MODE_W-1:0] MODE_PAL8  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RGB15 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RGB16 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RGB24 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RGB32 = 3'd4;

    // operations
    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    // register indexes
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEPTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_FLIP   = 2'd3;

    // item passed from front to back through the queue
    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] data;
        logic [PAL_AW-1:0] index;
        logic [ROW_W-1:0]  stored_row;
        logic [COL_W-1:0]  column;
        logic              last;
    } pf2b_item_t;

    // settings the back end needs
    typedef struct packed {
        logic [MODE_W-1:0] depth_mode;
        logic [ROWB_W-1:0] row_bytes;
    } pf2b_cfg_t;

endpackage

### design/pf2b_fifo.sv
// pf2b_fifo: short item queue between front and back
// depends on pf2b_pkg (pf2b_item_t, FIFO_DEPTH)

module pf2b_fifo
    import pf2b_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pf2b_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output pf2b_item_t head_item
);

    pf2b_item_t         slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    assign full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count past depth");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not raise count");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

### design/pf2b_front.sv
// pf2b_front: config registers, input accept, frame position counters
// depends on pf2b_pkg (codes, widths, pf2b_item_t, pf2b_cfg_t)

module pf2b_front
    import pf2b_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DIM_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [PIX_W-1:0]  pixel_value,
    input  logic [BYTE_W-1:0] entry_index,
    input  logic [BYTE_W-1:0] entry_byte_first,
    input  logic [BYTE_W-1:0] entry_byte_second,
    input  logic [BYTE_W-1:0] entry_byte_third,
    input  logic              fifo_full,
    output logic              push,
    output pf2b_item_t        push_item,
    output pf2b_cfg_t         back_cfg
);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              flip_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;

    logic              cfg_we;
    logic              in_fire;
    logic              pixel_fire;
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              col_wrap;
    logic              row_wrap;
    logic [ROW_W-1:0]  stored_row;
    logic [ROWB_W-1:0] rb_sum;

    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign in_ready   = !fifo_full;
    assign in_fire    = in_valid && in_ready;
    assign pixel_fire = in_fire && (operation == OP_PIXEL);
    assign push       = in_fire;

    // zero counts as one, oversize counts as the maximum
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (width_reg > MAX_W_DIM)
        begin
            w_eff = MAX_W_DIM;
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (height_reg > MAX_H_DIM)
        begin
            h_eff = MAX_H_DIM;
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign col_wrap   = (DIM_W'(col_reg) + 1'b1) >= w_eff;
    assign row_wrap   = (DIM_W'(row_reg) + 1'b1) >= h_eff;
    assign stored_row = flip_reg ? ROW_W'(h_eff - 1'b1 - DIM_W'(row_reg)) : row_reg;

    // row pitch rounded up to four bytes
    assign rb_sum = ROWB_W'({w_eff, 1'b0}) + ROWB_W'(w_eff) + ROWB_W'(3);
    assign back_cfg.row_bytes  = {rb_sum[ROWB_W-1:2], 2'b00};
    assign back_cfg.depth_mode = mode_reg;

    always_comb
    begin
        push_item.op         = operation;
        push_item.stored_row = stored_row;
        push_item.column     = col_reg;
        push_item.last       = col_wrap && row_wrap;
        if (operation == OP_PALETTE)
        begin
            push_item.data  = {entry_byte_third, entry_byte_second, entry_byte_first};
            push_item.index = entry_index[PAL_AW-1:0];
        end
        else
        begin
            push_item.data  = pixel_value[DATA_W-1:0];
            push_item.index = pixel_value[PAL_AW-1:0];
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (pixel_fire)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
            mode_reg   <= MODE_RGB24;
            flip_reg   <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_DEPTH:  mode_reg   <= cfg_data[MODE_W-1:0];
                    REG_FLIP:   flip_reg   <= cfg_data[0];
                    default:    width_reg  <= width_reg;
                endcase
            end
        end
    end

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(col_reg) < w_eff)
        else $error("column past frame width");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (col_reg == '0) && (row_reg == '0))
        else $error("config write did not restart frame");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_fire && col_wrap && row_wrap && !cfg_we) |=>
            (col_reg == '0) && (row_reg == '0))
        else $error("counters did not wrap at frame end");

endmodule

### design/pf2b_back.sv
// pf2b_back: palette store, offset multiply and byte conversion, output register
// depends on pf2b_pkg (codes, widths, pf2b_item_t, pf2b_cfg_t)

module pf2b_back
    import pf2b_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pf2b_cfg_t           back_cfg,
    input  logic                fifo_not_empty,
    input  pf2b_item_t          head_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OFFSET_W-1:0] byte_offset,
    output logic [BYTE_W-1:0]   out_first,
    output logic [BYTE_W-1:0]   out_second,
    output logic [BYTE_W-1:0]   out_third,
    output logic                frame_end
);

    logic [DATA_W-1:0]   pal_mem [PALETTE_ENTRIES];
    logic [DATA_W-1:0]   pal_rd_reg;

    logic                s1_valid_reg;
    logic                s1_op_reg;
    logic [DATA_W-1:0]   s1_data_reg;
    logic [OFFSET_W-1:0] s1_prod_reg;
    logic [ROWB_W-1:0]   s1_col3_reg;
    logic                s1_last_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic [DATA_W-1:0]   bytes_reg;
    logic [DATA_W-1:0]   bytes_next;
    logic                last_reg;

    logic                out_adv;
    logic                s1_free;
    logic [BYTE_W*2-1:0] p16;

    assign out_adv = !out_valid_reg || out_ready;
    // a palette write leaves stage one without producing a result
    assign s1_free = !s1_valid_reg || (s1_op_reg == OP_PALETTE) || out_adv;
    assign pop     = fifo_not_empty && s1_free;

    always_ff @(posedge clk)
    begin
        if (pop && (head_item.op == OP_PALETTE))
        begin
            pal_mem[head_item.index] <= head_item.data;
        end
        if (pop && (head_item.op == OP_PIXEL))
        begin
            pal_rd_reg <= pal_mem[head_item.index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_op_reg   <= head_item.op;
            s1_data_reg <= head_item.data;
            s1_prod_reg <= OFFSET_W'(head_item.stored_row) * OFFSET_W'(back_cfg.row_bytes);
            s1_col3_reg <= ROWB_W'({head_item.column, 1'b0}) + ROWB_W'(head_item.column);
            s1_last_reg <= head_item.last;
        end
    end

    // channel widening by top-bit replication
    assign p16 = s1_data_reg[BYTE_W*2-1:0];

    always_comb
    begin
        case (back_cfg.depth_mode)
            MODE_PAL8:
                bytes_next = pal_rd_reg;
            MODE_RGB15:
                bytes_next = {p16[14:10], p16[14:12],
                              p16[9:5], p16[9:7],
                              p16[4:0], p16[4:2]};
            MODE_RGB16:
                bytes_next = {p16[15:11], p16[15:13],
                              p16[10:5], p16[10:9],
                              p16[4:0], p16[4:2]};
            MODE_RGB24, MODE_RGB32:
                bytes_next = s1_data_reg;
            default:
                bytes_next = s1_data_reg;
        endcase
    end

    assign out_valid_next = out_adv ? (s1_valid_reg && (s1_op_reg == OP_PIXEL))
                                    : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= pop;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg && (s1_op_reg == OP_PIXEL))
        begin
            offset_reg <= s1_prod_reg + OFFSET_W'(s1_col3_reg);
            bytes_reg  <= bytes_next;
            last_reg   <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_offset = offset_reg;
    assign out_first   = bytes_reg[BYTE_W-1:0];
    assign out_second  = bytes_reg[BYTE_W*2-1:BYTE_W];
    assign out_third   = bytes_reg[DATA_W-1:BYTE_W*2];
    assign frame_end   = last_reg;

    a_stage_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> s1_valid_reg)
        else $error("popped item not in stage one");

    a_pixel_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_op_reg == OP_PIXEL) && out_adv) |=> out_valid_reg)
        else $error("pixel item lost between stage one and output");

    a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_op_reg == OP_PIXEL) && !out_adv) |=>
            (s1_valid_reg && $stable(s1_prod_reg) && $stable(s1_last_reg)))
        else $error("stage one changed while output stalled");

endmodule

### design/pixel_format_to_bgr24_top.sv
// an accepted pixel item is registered in the queue, then in stage one, then in the output register
// throughput: one item per cycle while the output does not stall, palette writes included;
//   front counters, queue pop and palette memory read port each handle one item a cycle
// a 4-entry queue parts input acceptance from output stalls
// reset: asynchronous, active low; registers return to 640x480, 24 bit, no flip,
//   counters to zero; palette contents are undefined until written
// top level: ties front, queue and back together; depends on pf2b_pkg

module pixel_format_to_bgr24_top
    import pf2b_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [DIM_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic [PIX_W-1:0]    pixel_value,
    input  logic [BYTE_W-1:0]   entry_index,
    input  logic [BYTE_W-1:0]   entry_byte_first,
    input  logic [BYTE_W-1:0]   entry_byte_second,
    input  logic [BYTE_W-1:0]   entry_byte_third,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OFFSET_W-1:0] byte_offset,
    output logic [BYTE_W-1:0]   out_first,
    output logic [BYTE_W-1:0]   out_second,
    output logic [BYTE_W-1:0]   out_third,
    output logic                frame_end
);

    logic       push;
    logic       pop;
    logic       fifo_full;
    logic       fifo_not_empty;
    pf2b_item_t push_item;
    pf2b_item_t head_item;
    pf2b_cfg_t  back_cfg;

    pf2b_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .pixel_value       (pixel_value),
        .entry_index       (entry_index),
        .entry_byte_first  (entry_byte_first),
        .entry_byte_second (entry_byte_second),
        .entry_byte_third  (entry_byte_third),
        .fifo_full         (fifo_full),
        .push              (push),
        .push_item         (push_item),
        .back_cfg          (back_cfg)
    );

    pf2b_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (fifo_not_empty),
        .head_item (head_item)
    );

    pf2b_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .back_cfg       (back_cfg),
        .fifo_not_empty (fifo_not_empty),
        .head_item      (head_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .byte_offset    (byte_offset),
        .out_first      (out_first),
        .out_second     (out_second),
        .out_third      (out_third),
        .frame_end      (frame_end)
    );

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for pixel_format_to_bgr24_top; a directed table, then random phases
// with varied geometry, depth and handshake idling; depends on pf2b_pkg and the design sources

module tb;
    import pf2b_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 116;
    localparam int DRAIN_CYCLES    = 12;

    // depth code outside the defined set, decoded like 32 bit
    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [OFFSET_W-1:0] offs;
        logic [BYTE_W-1:0]   b_first;
        logic [BYTE_W-1:0]   b_second;
        logic [BYTE_W-1:0]   b_third;
        logic                fend;
    } pixel_result_t;

    typedef struct packed {
        logic                is_reg;
        logic [IDX_W-1:0]    reg_idx;
        logic [DIM_W-1:0]    reg_val;
        logic                op;
        logic [PIX_W-1:0]    pix;
        logic [BYTE_W-1:0]   idx;
        logic [BYTE_W-1:0]   e_first;
        logic [BYTE_W-1:0]   e_second;
        logic [BYTE_W-1:0]   e_third;
        logic                known;
        pixel_result_t       result;
    } script_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [DIM_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                operation = OP_PIXEL;
    logic [PIX_W-1:0]    pixel_value = '0;
    logic [BYTE_W-1:0]   entry_index = '0;
    logic [BYTE_W-1:0]   entry_byte_first = '0;
    logic [BYTE_W-1:0]   entry_byte_second = '0;
    logic [BYTE_W-1:0]   entry_byte_third = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [OFFSET_W-1:0] byte_offset;
    logic [BYTE_W-1:0]   out_first;
    logic [BYTE_W-1:0]   out_second;
    logic [BYTE_W-1:0]   out_third;
    logic                frame_end;

    // shadow of the block: registers, frame position, palette
    logic [DIM_W-1:0]    set_w = DIM_W'(640);
    logic [DIM_W-1:0]    set_h = DIM_W'(480);
    logic [MODE_W-1:0]   set_mode = MODE_RGB24;
    logic                set_flip = 1'b0;
    int unsigned         col_pos = 0;
    int unsigned         row_pos = 0;
    logic [DATA_W-1:0]   palette [PALETTE_ENTRIES];
    bit                  pal_written [PALETTE_ENTRIES];
    logic [BYTE_W-1:0]   written_entries [$];

    pixel_result_t       pending_pixels [$];
    script_row_t         script [$];

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  error_count = 0;
    int                  items_sent = 0;
    int                  palette_writes = 0;
    int                  pixels_checked = 0;
    int                  frame_ends = 0;
    int                  reg_writes = 0;
    int                  cycle_count = 0;

    pixel_format_to_bgr24_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    function automatic int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    function automatic void apply_reg(logic [IDX_W-1:0] i, logic [DIM_W-1:0] v);
        case (i)
            REG_WIDTH:  set_w = v;
            REG_HEIGHT: set_h = v;
            REG_DEPTH:  set_mode = v[MODE_W-1:0];
            REG_FLIP:   set_flip = v[0];
            default:    ;
        endcase
        // any write restarts the frame
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic void store_entry(script_row_t r);
        palette[r.idx] = {r.e_third, r.e_second, r.e_first};
        if (!pal_written[r.idx])
        begin
            pal_written[r.idx] = 1'b1;
            written_entries.push_back(r.idx);
        end
    endfunction

    function automatic pixel_result_t convert_pixel(logic [PIX_W-1:0] pix);
        int unsigned       w;
        int unsigned       h;
        int unsigned       row_bytes;
        int unsigned       stored_row;
        longint unsigned   offs;
        logic [15:0]       p;
        logic [DATA_W-1:0] entry;
        pixel_result_t     r;
        w = fit_dim(set_w, MAX_WIDTH);
        h = fit_dim(set_h, MAX_HEIGHT);
        if (col_pos >= w)
            col_pos = w - 1;
        if (row_pos >= h)
            row_pos = h - 1;
        p = pix[15:0];
        case (set_mode)
            MODE_PAL8:
            begin
                entry = palette[pix[7:0]];
                r.b_first  = entry[7:0];
                r.b_second = entry[15:8];
                r.b_third  = entry[23:16];
            end
            MODE_RGB15:
            begin
                r.b_first  = {p[4:0], p[4:2]};
                r.b_second = {p[9:5], p[9:7]};
                r.b_third  = {p[14:10], p[14:12]};
            end
            MODE_RGB16:
            begin
                r.b_first  = {p[4:0], p[4:2]};
                r.b_second = {p[10:5], p[10:9]};
                r.b_third  = {p[15:11], p[15:13]};
            end
            default:
            begin
                r.b_first  = pix[7:0];
                r.b_second = pix[15:8];
                r.b_third  = pix[23:16];
            end
        endcase
        row_bytes  = ((w * 3 + 3) / 4) * 4;
        stored_row = set_flip ? (h - 1 - row_pos) : row_pos;
        offs = longint'(stored_row) * row_bytes + longint'(col_pos) * 3;
        r.offs = offs[OFFSET_W-1:0];
        r.fend = (col_pos + 1 >= w) && (row_pos + 1 >= h);
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos++;
        return r;
    endfunction

    function automatic script_row_t reg_row(logic [IDX_W-1:0] i, logic [DIM_W-1:0] v);
        script_row_t r;
        r = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = i;
        r.reg_val = v;
        return r;
    endfunction

    function automatic script_row_t pix_row(logic [PIX_W-1:0] pix);
        script_row_t r;
        r = '0;
        r.op       = OP_PIXEL;
        r.pix      = pix;
        r.idx      = BYTE_W'($urandom);
        r.e_first  = BYTE_W'($urandom);
        r.e_second = BYTE_W'($urandom);
        r.e_third  = BYTE_W'($urandom);
        return r;
    endfunction

    function automatic script_row_t pix_known(logic [PIX_W-1:0] pix, logic [OFFSET_W-1:0] offs,
                                              logic [BYTE_W-1:0] f, logic [BYTE_W-1:0] s,
                                              logic [BYTE_W-1:0] t, logic fend);
        script_row_t r;
        r = pix_row(pix);
        r.known  = 1'b1;
        r.result = {offs, f, s, t, fend};
        return r;
    endfunction

    function automatic script_row_t pal_row(logic [BYTE_W-1:0] i, logic [BYTE_W-1:0] f,
                                            logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] t);
        script_row_t r;
        r = '0;
        r.op       = OP_PALETTE;
        r.pix      = $urandom;
        r.idx      = i;
        r.e_first  = f;
        r.e_second = s;
        r.e_third  = t;
        return r;
    endfunction

    function automatic script_row_t random_row(bit pal_phase);
        script_row_t r;
        r = pix_row($urandom);
        if ($urandom_range(0, 99) < (pal_phase ? 25 : 10))
            r.op = OP_PALETTE;
        // in palette mode only entries already loaded are looked up
        if (pal_phase && r.op == OP_PIXEL)
            r.pix[7:0] = written_entries[$urandom_range(0, written_entries.size() - 1)];
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return DIM_W'($urandom_range(1, 12));
        if (sel < 80)
            return '0;
        if (sel < 88)
            return DIM_W'($urandom_range(MAX_WIDTH, 8191));
        return DIM_W'($urandom_range(13, 400));
    endfunction

    task automatic push_item(script_row_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        operation         <= r.op;
        pixel_value       <= r.pix;
        entry_index       <= r.idx;
        entry_byte_first  <= r.e_first;
        entry_byte_second <= r.e_second;
        entry_byte_third  <= r.e_third;
        in_valid          <= 1'b1;
        // signals are settled at the falling edge, so this is the next rising edge's handshake
        do
            @(negedge clk);
        while (!in_ready);
        if (r.op == OP_PALETTE)
        begin
            store_entry(r);
            palette_writes++;
        end
        else if (r.known)
        begin
            void'(convert_pixel(r.pix));
            pending_pixels.push_back(r.result);
        end
        else
            pending_pixels.push_back(convert_pixel(r.pix));
        items_sent++;
        @(posedge clk);
    endtask

    task automatic reg_write(logic [IDX_W-1:0] i, logic [DIM_W-1:0] v);
        cfg_index <= i;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_ready);
        apply_reg(i, v);
        reg_writes++;
        @(posedge clk);
    endtask

    // stop sending and let the pipe run dry, palette writes included
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(negedge clk)
    begin
        pixel_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel item with none pending: offset %0h", byte_offset);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("byte_offset", 32'(want.offs), 32'(byte_offset));
                check_field("out_first", 32'(want.b_first), 32'(out_first));
                check_field("out_second", 32'(want.b_second), 32'(out_second));
                check_field("out_third", 32'(want.b_third), 32'(out_third));
                check_field("frame_end", 32'(want.fend), 32'(frame_end));
                pixels_checked++;
                if (frame_end)
                    frame_ends++;
            end
        end
    end

    initial
    begin
        script_row_t       row;
        bit                cfg_open;
        logic [MODE_W-1:0] mode;

        // after reset: 640x480, 24 bit, rows top-down
        script.push_back(pix_known(32'hffff_ffff, 26'd0, 8'hff, 8'hff, 8'hff, 1'b0));
        script.push_back(pix_known(32'h0000_0000, 26'd3, 8'h00, 8'h00, 8'h00, 1'b0));
        script.push_back(pix_known(32'h00a1_b2c3, 26'd6, 8'hc3, 8'hb2, 8'ha1, 1'b0));
        // 2x2 frame, rows padded to 8 bytes, alpha dropped
        script.push_back(reg_row(REG_WIDTH, 13'd2));
        script.push_back(reg_row(REG_HEIGHT, 13'd2));
        script.push_back(reg_row(REG_DEPTH, DIM_W'(MODE_RGB32)));
        script.push_back(pix_known(32'hdead_beef, 26'd0, 8'hef, 8'hbe, 8'had, 1'b0));
        script.push_back(pix_known(32'h7f00_0001, 26'd3, 8'h01, 8'h00, 8'h00, 1'b0));
        script.push_back(pix_known(32'h0000_0000, 26'd8, 8'h00, 8'h00, 8'h00, 1'b0));
        script.push_back(pix_known(32'hffff_ffff, 26'd11, 8'hff, 8'hff, 8'hff, 1'b1));
        // 15 bit: top bit ignored
        script.push_back(reg_row(REG_DEPTH, DIM_W'(MODE_RGB15)));
        script.push_back(pix_known(32'hffff_7fff, 26'd0, 8'hff, 8'hff, 8'hff, 1'b0));
        script.push_back(pix_known(32'h0000_8000, 26'd3, 8'h00, 8'h00, 8'h00, 1'b0));
        script.push_back(pix_row(32'h0000_4210));
        script.push_back(reg_row(REG_DEPTH, DIM_W'(MODE_RGB16)));
        script.push_back(pix_known(32'h0000_ffff, 26'd0, 8'hff, 8'hff, 8'hff, 1'b0));
        script.push_back(pix_known(32'hffff_0000, 26'd3, 8'h00, 8'h00, 8'h00, 1'b0));
        script.push_back(pix_row(32'h0000_8410));
        // palette: load both end entries before any lookup
        script.push_back(reg_row(REG_DEPTH, DIM_W'(MODE_PAL8)));
        script.push_back(pal_row(8'h00, 8'h11, 8'h22, 8'h33));
        script.push_back(pal_row(8'hff, 8'hff, 8'h00, 8'h80));
        script.push_back(pix_known(32'hffff_ff00, 26'd0, 8'h11, 8'h22, 8'h33, 1'b0));
        script.push_back(pix_known(32'h0000_00ff, 26'd3, 8'hff, 8'h00, 8'h80, 1'b0));
        script.push_back(reg_row(REG_DEPTH, DIM_W'(MODE_UNKNOWN)));
        script.push_back(pix_known(32'h0102_0304, 26'd0, 8'h04, 8'h03, 8'h02, 1'b0));
        // zero width counts as 1, oversize height as the maximum, bottom-up rows
        script.push_back(reg_row(REG_WIDTH, 13'd0));
        script.push_back(reg_row(REG_HEIGHT, 13'h1fff));
        script.push_back(reg_row(REG_FLIP, 13'd1));
        script.push_back(reg_row(REG_DEPTH, DIM_W'(MODE_RGB24)));
        script.push_back(pix_known(32'haabb_ccdd, 26'd16380, 8'hdd, 8'hcc, 8'hbb, 1'b0));
        script.push_back(pix_row(32'h55aa_33cc));
        script.push_back(reg_row(REG_WIDTH, 13'h1fff));
        script.push_back(reg_row(REG_HEIGHT, 13'd1));
        script.push_back(pix_known(32'h1234_5678, 26'd0, 8'h78, 8'h56, 8'h34, 1'b0));
        // largest frame flipped: first pixel lands at the start of the last row
        script.push_back(reg_row(REG_HEIGHT, DIM_W'(MAX_HEIGHT)));
        script.push_back(pix_known(32'h00ff_eedd, 26'd50319360, 8'hdd, 8'hee, 8'hff, 1'b0));
        script.push_back(reg_row(REG_WIDTH, 13'd1));
        script.push_back(reg_row(REG_HEIGHT, 13'd1));
        script.push_back(reg_row(REG_FLIP, 13'd0));
        script.push_back(pix_known(32'h8070_6050, 26'd0, 8'h50, 8'h60, 8'h70, 1'b1));
        script.push_back(pix_known(32'hffff_ffff, 26'd0, 8'hff, 8'hff, 8'hff, 1'b1));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_open = 1'b0;
        foreach (script[k])
        begin
            row = script[k];
            if (row.is_reg)
            begin
                if (!cfg_open)
                    settle();
                reg_write(row.reg_idx, row.reg_val);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                    cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                push_item(row);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case ((ph / 4) % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            mode = MODE_W'((ph * 3) % 8);
            reg_write(REG_WIDTH, pick_dim());
            reg_write(REG_HEIGHT, pick_dim());
            // unused upper data bits are random
            reg_write(REG_DEPTH, {(DIM_W - MODE_W)'($urandom), mode});
            reg_write(REG_FLIP, DIM_W'($urandom));
            cfg_valid <= 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph % 5 == 2 && n == ITEMS_PER_PHASE / 2)
                    settle();
                push_item(random_row(set_mode == MODE_PAL8));
            end
        end

        settle();
        $display("summary: %0d items (%0d palette writes), %0d register writes",
                 items_sent, palette_writes, reg_writes);
        $display("summary: %0d pixels compared, %0d frame ends seen, %0d palette entries used",
                 pixels_checked, frame_ends, written_entries.size());
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
